@@ design/fcv_pkg.sv @@
package fcv_pkg;

	localparam int unsigned COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME   = 32'd16777619;
	localparam logic [31:0] FRAME_MAGIC = 32'h51435a31;
	localparam logic [7:0]  FRAME_VERSION = 8'd1;
	localparam logic [COUNT_W-1:0] HDR_BYTES = COUNT_W'(28);
	localparam logic [COUNT_W-1:0] CSUM_AT   = COUNT_W'(24);

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_LENGTH   = 3'd3,
		ST_CHECKSUM = 3'd4
	} status_t;

	// Header fields and running totals of a frame, as seen after one byte.
	typedef struct packed {
		logic [COUNT_W-1:0] byte_count;
		logic [31:0]        running_hash;
		logic [31:0]        magic_word;
		logic [7:0]         version_byte;
		logic [7:0]         type_byte;
		logic [15:0]        header_length;
		logic [15:0]        length_of_payload;
		logic [15:0]        flag_bits;
		logic [31:0]        seq_word;
		logic [63:0]        time_word;
		logic [31:0]        stored_checksum;
	} frame_sum_t;

	// Product with the FNV prime, 2^24 + 2^8 + 0x93, as a sum of shifts.
	function automatic logic [31:0] fnv_mul(input logic [31:0] x);
		fnv_mul = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

@@ design/fcv_if.sv @@
interface fcv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_frame;

	modport source(output valid, output data_byte, output end_of_frame, input ready);
	modport sink(input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface fcv_out_if;
	logic                    valid;
	logic                    ready;
	fcv_pkg::status_t        status;
	logic [7:0]              message_type;
	logic [15:0]             header_flags;
	logic [31:0]             sequence_number;
	logic [63:0]             timestamp;
	logic [15:0]             payload_length;

	modport source(output valid, output status, output message_type, output header_flags,
		output sequence_number, output timestamp, output payload_length, input ready);
	modport sink(input valid, input status, input message_type, input header_flags,
		input sequence_number, input timestamp, input payload_length, output ready);
endinterface

@@ design/fcv_accum.sv @@
module fcv_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               end_of_frame,
	output fcv_pkg::frame_sum_t nxt
);

	fcv_pkg::frame_sum_t cur_q;
	fcv_pkg::frame_sum_t rst_val;
	logic [7:0]          hash_byte;
	logic [4:0]          pos;

	assign pos = cur_q.byte_count[4:0];

	always_comb begin
		rst_val = '0;
		rst_val.running_hash = fcv_pkg::FNV_BASIS;
	end

	always_comb begin
		nxt = cur_q;
		// The stored checksum bytes are hashed as zero.
		if (cur_q.byte_count >= fcv_pkg::CSUM_AT && cur_q.byte_count < fcv_pkg::HDR_BYTES) begin
			hash_byte = 8'd0;
		end else begin
			hash_byte = data_byte;
		end
		nxt.running_hash = fcv_pkg::fnv_mul(cur_q.running_hash ^ {24'd0, hash_byte});
		if (cur_q.byte_count != fcv_pkg::COUNT_MAX) begin
			nxt.byte_count = cur_q.byte_count + fcv_pkg::COUNT_W'(1);
		end
		if (cur_q.byte_count < fcv_pkg::HDR_BYTES) begin
			case (pos) inside
				[5'd0:5'd3]:   nxt.magic_word = {cur_q.magic_word[23:0], data_byte};
				5'd4:          nxt.version_byte = data_byte;
				5'd5:          nxt.type_byte = data_byte;
				[5'd6:5'd7]:   nxt.header_length = {cur_q.header_length[7:0], data_byte};
				[5'd8:5'd9]:   nxt.length_of_payload = {cur_q.length_of_payload[7:0], data_byte};
				[5'd10:5'd11]: nxt.flag_bits = {cur_q.flag_bits[7:0], data_byte};
				[5'd12:5'd15]: nxt.seq_word = {cur_q.seq_word[23:0], data_byte};
				[5'd16:5'd23]: nxt.time_word = {cur_q.time_word[55:0], data_byte};
				[5'd24:5'd27]: nxt.stored_checksum = {cur_q.stored_checksum[23:0], data_byte};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= rst_val;
		end else if (step) begin
			if (end_of_frame) begin
				cur_q <= rst_val;
			end else begin
				cur_q <= nxt;
			end
		end
	end

endmodule

@@ design/fcv_judge.sv @@
module fcv_judge (
	input  fcv_pkg::frame_sum_t fin,
	output fcv_pkg::status_t    status
);

	logic [fcv_pkg::COUNT_W-1:0] total;

	assign total = {1'b0, fin.header_length} + {1'b0, fin.length_of_payload};

	always_comb begin
		if (fin.byte_count < fcv_pkg::HDR_BYTES) begin
			status = fcv_pkg::ST_SHORT;
		end else if (fin.magic_word != fcv_pkg::FRAME_MAGIC
				|| fin.version_byte != fcv_pkg::FRAME_VERSION) begin
			status = fcv_pkg::ST_MAGIC;
		end else if (fin.header_length != fcv_pkg::HDR_BYTES[15:0]
				|| fin.byte_count != total) begin
			status = fcv_pkg::ST_LENGTH;
		end else if (fin.stored_checksum != fin.running_hash) begin
			status = fcv_pkg::ST_CHECKSUM;
		end else begin
			status = fcv_pkg::ST_OK;
		end
	end

endmodule

@@ design/checksummed_frame_validator.sv @@
// Frame header validator with a 32-bit FNV-1a hash over the whole frame.
// The frame channel takes one byte per item, in wire order; end_of_frame
// marks the last byte. Bytes without the mark give no result. The result
// channel gives one item per frame: a status code, and when the status is
// ok the message type, flags, sequence number, timestamp and payload length
// from the 28-byte header (all zero otherwise). The checksum bytes at
// offsets 24 to 27 are hashed as zero and compared with the final hash.
// Throughput is one byte per cycle, except while a last byte waits on a
// stalled result. A byte is held in the input register; the hash step,
// header capture and status decision run combinationally as it leaves
// that register, and the result register captures the verdict when a
// frame's last byte leaves it. The per-byte path is one constant multiply
// (shift-and-add) followed by the checksum compare. Reset clears the valid
// flags of the input and result registers and returns the frame state to
// the hash basis with an empty header. If the receiver stalls, the result
// holds steady; body bytes keep flowing, and only a last byte waits in the
// input register until the result register frees up, with frame.ready low.
module checksummed_frame_validator (
	input  logic             clk,
	input  logic             arst_n,
	fcv_in_if.sink           frame,
	fcv_out_if.source        result
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eof_s1;
	logic       out_free;
	logic       adv;
	logic       accept;

	fcv_pkg::frame_sum_t nxt;
	fcv_pkg::status_t    status_d;

	logic                    out_valid_q;
	fcv_pkg::status_t        status_q;
	logic [7:0]              type_q;
	logic [15:0]             flags_q;
	logic [31:0]             seq_q;
	logic [63:0]             time_q;
	logic [15:0]             plen_q;

	// The input register moves on unless it holds a last byte and the result
	// register is still occupied.
	assign out_free = !out_valid_q || result.ready;
	assign adv = valid_s1 && (!eof_s1 || out_free);
	assign frame.ready = !valid_s1 || adv;
	assign accept = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= frame.data_byte;
			eof_s1 <= frame.end_of_frame;
		end
	end

	fcv_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.data_byte    (data_s1),
		.end_of_frame (eof_s1),
		.nxt          (nxt)
	);

	fcv_judge u_judge (
		.fin    (nxt),
		.status (status_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Header fields are reported only for a frame that passed every check.
	always_ff @(posedge clk) begin
		if (adv && eof_s1) begin
			status_q <= status_d;
			if (status_d == fcv_pkg::ST_OK) begin
				type_q  <= nxt.type_byte;
				flags_q <= nxt.flag_bits;
				seq_q   <= nxt.seq_word;
				time_q  <= nxt.time_word;
				plen_q  <= nxt.length_of_payload;
			end else begin
				type_q  <= '0;
				flags_q <= '0;
				seq_q   <= '0;
				time_q  <= '0;
				plen_q  <= '0;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = status_q;
	assign result.message_type    = type_q;
	assign result.header_flags    = flags_q;
	assign result.sequence_number = seq_q;
	assign result.timestamp       = time_q;
	assign result.payload_length  = plen_q;

endmodule

@@ design/fcv_checker.sv @@
module fcv_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             frame_ready,
	input logic             result_valid,
	input logic             result_ready,
	input fcv_pkg::status_t status,
	input logic [7:0]       message_type,
	input logic [15:0]      header_flags,
	input logic [31:0]      sequence_number,
	input logic [63:0]      timestamp,
	input logic [15:0]      payload_length
);

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status)
			&& $stable(sequence_number) && $stable(timestamp))
		else $error("stalled result changed");

	// With the receiver ready, nothing blocks the byte stream.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> frame_ready)
		else $error("frame stalled while result side is ready");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= fcv_pkg::ST_CHECKSUM)
		else $error("status code out of range");

	// A failed frame reports no header fields.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != fcv_pkg::ST_OK |-> message_type == 8'd0
			&& header_flags == 16'd0 && sequence_number == 32'd0
			&& timestamp == 64'd0 && payload_length == 16'd0)
		else $error("failed frame carries header fields");

endmodule

bind checksummed_frame_validator fcv_checker u_fcv_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.frame_ready     (frame.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.status          (result.status),
	.message_type    (result.message_type),
	.header_flags    (result.header_flags),
	.sequence_number (result.sequence_number),
	.timestamp       (result.timestamp),
	.payload_length  (result.payload_length)
);

@@ sim/tb_checksummed_frame_validator.sv @@
module tb_checksummed_frame_validator;
	timeunit 1ns;
	timeprecision 1ps;

	// The run normally ends far below this, even with every byte a one-byte
	// frame and the receiver stalling most of the time.
	localparam int CYCLE_LIMIT = 50_000;

	// Bytes of random traffic queued in each idling phase.
	localparam int PHASE_BYTES = 280;

	// Cycles that the receiver holds off during the back-pressure phase.
	localparam int HOLD_CYCLES = 400;

	// Cycles that pass after the last result before the final verdict.
	// This leaves room for a stray result to show up.
	localparam int TAIL_CYCLES = 16;

	// One byte of the frame channel as the stimulus queues it.
	typedef struct {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	// One expected item of the result channel.
	typedef struct {
		fcv_pkg::status_t status;
		logic [7:0]       message_type;
		logic [15:0]      header_flags;
		logic [31:0]      sequence_number;
		logic [63:0]      timestamp;
		logic [15:0]      payload_length;
	} verdict_t;

	// Header fields and running hash of the frame under way, as the
	// block should hold them after each accepted byte.
	typedef struct {
		logic [fcv_pkg::COUNT_W-1:0] count;
		logic [31:0]                 hash;
		logic [31:0]                 magic;
		logic [7:0]                  version;
		logic [7:0]                  kind;
		logic [15:0]                 hdr_len;
		logic [15:0]                 pay_len;
		logic [15:0]                 flags;
		logic [31:0]                 seq;
		logic [63:0]                 stamp;
		logic [31:0]                 csum;
	} frame_track_t;

	// Ways of building a frame for the stimulus.
	typedef enum {
		FK_GOOD,
		FK_BAD_CSUM,
		FK_BAD_MAGIC,
		FK_BAD_VERSION,
		FK_BAD_HLEN,
		FK_BAD_TOTAL
	} frame_kind_e;

	// How the header fields and payload of a built frame are filled.
	typedef enum {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_e;

	logic clk;
	logic arst_n;

	fcv_in_if  frame_ch ();
	fcv_out_if result_ch ();

	checksummed_frame_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	wire_byte_t   pending_bytes[$];
	verdict_t     expected_verdicts[$];
	frame_track_t track;

	int  queued_bytes;
	int  mismatches;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_left;
	bit  byte_taken;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// One step of the FNV-1a hash.
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		return (h ^ {24'd0, b}) * fcv_pkg::FNV_PRIME;
	endfunction

	// Back to the state of an empty frame: the hash basis and a blank header.
	function automatic void clear_track();
		track.count   = '0;
		track.hash    = fcv_pkg::FNV_BASIS;
		track.magic   = '0;
		track.version = '0;
		track.kind    = '0;
		track.hdr_len = '0;
		track.pay_len = '0;
		track.flags   = '0;
		track.seq     = '0;
		track.stamp   = '0;
		track.csum    = '0;
	endfunction

	// Folds one accepted byte into the tracked frame. On the last byte of a
	// frame it works out the verdict the block must give, then starts over.
	function automatic void track_byte(input logic [7:0] b, input logic last,
			output bit produced, output verdict_t v);
		logic [fcv_pkg::COUNT_W-1:0] pos;
		logic [fcv_pkg::COUNT_W-1:0] total;
		logic [7:0]                  hashed;

		pos = track.count;
		// The stored checksum bytes enter the hash as zero.
		hashed = (pos >= fcv_pkg::CSUM_AT && pos < fcv_pkg::CSUM_AT + 4) ? 8'd0 : b;
		track.hash = fnv_step(track.hash, hashed);

		if (pos < fcv_pkg::HDR_BYTES) begin
			if (pos <= 3)
				track.magic = {track.magic[23:0], b};
			else if (pos == 4)
				track.version = b;
			else if (pos == 5)
				track.kind = b;
			else if (pos <= 7)
				track.hdr_len = {track.hdr_len[7:0], b};
			else if (pos <= 9)
				track.pay_len = {track.pay_len[7:0], b};
			else if (pos <= 11)
				track.flags = {track.flags[7:0], b};
			else if (pos <= 15)
				track.seq = {track.seq[23:0], b};
			else if (pos <= 23)
				track.stamp = {track.stamp[55:0], b};
			else
				track.csum = {track.csum[23:0], b};
		end

		// The length counter sticks at its top value on very long frames.
		if (pos < fcv_pkg::COUNT_MAX)
			track.count = pos + 1'b1;

		produced = last;
		v.status          = fcv_pkg::ST_OK;
		v.message_type    = '0;
		v.header_flags    = '0;
		v.sequence_number = '0;
		v.timestamp       = '0;
		v.payload_length  = '0;

		if (last) begin
			total = track.count;
			if (total < fcv_pkg::HDR_BYTES)
				v.status = fcv_pkg::ST_SHORT;
			else if (track.magic != fcv_pkg::FRAME_MAGIC
					|| track.version != fcv_pkg::FRAME_VERSION)
				v.status = fcv_pkg::ST_MAGIC;
			else if (track.hdr_len != fcv_pkg::HDR_BYTES[15:0] ||
					total != fcv_pkg::COUNT_W'(track.hdr_len)
						+ fcv_pkg::COUNT_W'(track.pay_len))
				v.status = fcv_pkg::ST_LENGTH;
			else if (track.csum != track.hash)
				v.status = fcv_pkg::ST_CHECKSUM;

			// Header fields are reported only for a frame that passed.
			if (v.status == fcv_pkg::ST_OK) begin
				v.message_type    = track.kind;
				v.header_flags    = track.flags;
				v.sequence_number = track.seq;
				v.timestamp       = track.stamp;
				v.payload_length  = track.pay_len;
			end
			clear_track();
		end
	endfunction

	task automatic report(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	task automatic push_byte(input logic [7:0] data, input logic last);
		wire_byte_t wb;

		wb.data = data;
		wb.last = last;
		pending_bytes.push_back(wb);
		queued_bytes++;
	endtask

	// A frame of n random bytes with no regard to the header layout.
	task automatic push_raw(input int n);
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom), i == n - 1);
	endtask

	// Builds a frame with a proper header and checksum, then spoils the one
	// thing that its kind names. The checksum is computed after the header
	// has been spoiled, so only the intended check can fail. The payload
	// length field says plen while body_len bytes of payload really follow.
	task automatic build_frame(input frame_kind_e kind, input fill_e fill,
			input int plen, input int body_len);
		logic [7:0]  hdr [28];
		logic [7:0]  body [$];
		logic [31:0] magic;
		logic [31:0] seq;
		logic [31:0] hash;
		logic [7:0]  ver;
		logic [7:0]  mtype;
		logic [15:0] hlen;
		logic [15:0] flags;
		logic [15:0] plen16;
		logic [63:0] stamp;

		magic  = fcv_pkg::FRAME_MAGIC;
		ver    = fcv_pkg::FRAME_VERSION;
		hlen   = fcv_pkg::HDR_BYTES[15:0];
		plen16 = plen[15:0];
		case (fill)
			FILL_ZERO: begin
				mtype = '0;
				flags = '0;
				seq   = '0;
				stamp = '0;
			end
			FILL_ONES: begin
				mtype = '1;
				flags = '1;
				seq   = '1;
				stamp = '1;
			end
			default: begin
				mtype = 8'($urandom);
				flags = 16'($urandom);
				seq   = $urandom;
				stamp = {$urandom, $urandom};
			end
		endcase

		case (kind)
			FK_BAD_MAGIC: magic = magic ^ (32'd1 << $urandom_range(31));
			FK_BAD_VERSION: begin
				ver = 8'($urandom_range(255));
				if (ver == fcv_pkg::FRAME_VERSION)
					ver = 8'd0;
			end
			FK_BAD_HLEN: hlen = hlen ^ (16'd1 << $urandom_range(15));
			default: ;
		endcase

		for (int i = 0; i < 4; i++)
			hdr[i] = 8'(magic >> (8 * (3 - i)));
		hdr[4] = ver;
		hdr[5] = mtype;
		hdr[6] = hlen[15:8];
		hdr[7] = hlen[7:0];
		hdr[8] = plen16[15:8];
		hdr[9] = plen16[7:0];
		hdr[10] = flags[15:8];
		hdr[11] = flags[7:0];
		for (int i = 0; i < 4; i++)
			hdr[12 + i] = 8'(seq >> (8 * (3 - i)));
		for (int i = 0; i < 8; i++)
			hdr[16 + i] = 8'(stamp >> (8 * (7 - i)));
		for (int i = 24; i < 28; i++)
			hdr[i] = 8'd0;

		for (int i = 0; i < body_len; i++) begin
			case (fill)
				FILL_ZERO: body.push_back(8'h00);
				FILL_ONES: body.push_back(8'hff);
				default:   body.push_back(8'($urandom));
			endcase
		end

		hash = fcv_pkg::FNV_BASIS;
		for (int i = 0; i < 28; i++)
			hash = fnv_step(hash, hdr[i]);
		foreach (body[i])
			hash = fnv_step(hash, body[i]);
		if (kind == FK_BAD_CSUM)
			hash = hash ^ (32'd1 << $urandom_range(31));
		for (int i = 0; i < 4; i++)
			hdr[24 + i] = 8'(hash >> (8 * (3 - i)));

		for (int i = 0; i < 28; i++)
			push_byte(hdr[i], body_len == 0 && i == 27);
		for (int i = 0; i < body_len; i++)
			push_byte(body[i], i == body_len - 1);
	endtask

	// One frame of the random mix. Half the frames are well formed so that
	// the checksum compare and field capture see plenty of traffic; the
	// rest fail one check each, or are short or pure noise.
	task automatic random_frame();
		int pick;
		int plen;
		int body_len;

		pick = $urandom_range(99);
		plen = ($urandom_range(11) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
		if (pick < 50)
			build_frame(FK_GOOD, FILL_RANDOM, plen, plen);
		else if (pick < 60)
			build_frame(FK_BAD_CSUM, FILL_RANDOM, plen, plen);
		else if (pick < 66)
			build_frame(FK_BAD_MAGIC, FILL_RANDOM, plen, plen);
		else if (pick < 71)
			build_frame(FK_BAD_VERSION, FILL_RANDOM, plen, plen);
		else if (pick < 76)
			build_frame(FK_BAD_HLEN, FILL_RANDOM, plen, plen);
		else if (pick < 83) begin
			// The real payload is either shorter or longer than the field says.
			if (plen > 0 && $urandom_range(1) == 1)
				body_len = $urandom_range(0, plen - 1);
			else
				body_len = plen + $urandom_range(1, 8);
			build_frame(FK_BAD_TOTAL, FILL_RANDOM, plen, body_len);
		end else if (pick < 91)
			push_raw($urandom_range(1, 27));
		else
			push_raw($urandom_range(1, 80));
	endtask

	// Returns once every queued byte has gone in and every expected result
	// has come out. Sampled at the falling edge, away from the handshakes.
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || frame_ch.valid || expected_verdicts.size() != 0)
			@(negedge clk);
	endtask

	// Sender. At each falling edge it either keeps the byte on offer, or, once
	// the last one was taken, offers the next queued byte or idles.
	always @(negedge clk) begin
		wire_byte_t nb;

		if (arst_n) begin
			if (!frame_ch.valid || byte_taken) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nb = pending_bytes.pop_front();
					frame_ch.valid        <= 1'b1;
					frame_ch.data_byte    <= nb.data;
					frame_ch.end_of_frame <= nb.last;
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. It stalls at random, and all the time while a hold-off runs.
	always @(negedge clk)
		result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

	// The hold-off counts down in cycles on its own.
	always @(posedge clk)
		if (hold_left > 0)
			hold_left <= hold_left - 1;

	// Monitor. Every accepted byte goes through the predictor; every accepted
	// result is checked against the oldest expected verdict.
	always @(posedge clk) begin
		bit       produced;
		verdict_t v;
		verdict_t want;

		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else if (arst_n) begin
			byte_taken = 1'b0;
			if (frame_ch.valid && frame_ch.ready) begin
				track_byte(frame_ch.data_byte, frame_ch.end_of_frame, produced, v);
				if (produced)
					expected_verdicts.push_back(v);
				byte_taken = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					report("result item with no frame end waiting for it");
				end else begin
					want = expected_verdicts.pop_front();
					check_field("status", result_ch.status, want.status);
					check_field("message_type", result_ch.message_type, want.message_type);
					check_field("header_flags", result_ch.header_flags, want.header_flags);
					check_field("sequence_number", result_ch.sequence_number,
						want.sequence_number);
					check_field("timestamp", result_ch.timestamp, want.timestamp);
					check_field("payload_length", result_ch.payload_length,
						want.payload_length);
				end
			end
		end
	end

	initial begin
		int start_bytes;

		// Every input of the block is known from time zero.
		arst_n                = 1'b0;
		frame_ch.valid        = 1'b0;
		frame_ch.data_byte    = 8'd0;
		frame_ch.end_of_frame = 1'b0;
		result_ch.ready       = 1'b0;
		send_idle_pct         = 0;
		recv_stall_pct        = 0;
		hold_left             = 0;
		byte_taken            = 1'b0;
		queued_bytes          = 0;
		mismatches            = 0;
		cycle_count           = 0;
		clear_track();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames, at full rate on both sides.
		// A one-byte frame is short, whatever the byte.
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b1);
		// One byte short of a full header.
		push_raw(27);
		// The smallest good frame: header only, every reported field zero.
		build_frame(FK_GOOD, FILL_ZERO, 0, 0);
		// Each check failing on its own, in order of priority.
		build_frame(FK_BAD_MAGIC, FILL_RANDOM, 3, 3);
		build_frame(FK_BAD_VERSION, FILL_RANDOM, 0, 0);
		build_frame(FK_BAD_HLEN, FILL_RANDOM, 5, 5);
		build_frame(FK_BAD_TOTAL, FILL_RANDOM, 4, 9);
		build_frame(FK_BAD_TOTAL, FILL_RANDOM, 6, 2);
		build_frame(FK_BAD_CSUM, FILL_RANDOM, 7, 7);
		// A good frame right after failed ones shows the state was cleared.
		build_frame(FK_GOOD, FILL_RANDOM, 10, 10);
		// The message type, flags, sequence number and timestamp at their top values.
		build_frame(FK_GOOD, FILL_ONES, 64, 64);
		// A payload length field at its top value with a short real payload.
		build_frame(FK_BAD_TOTAL, FILL_ONES, 65535, 20);
		build_frame(FK_GOOD, FILL_RANDOM, 1, 1);
		wait_drained();

		// Back-pressure: the receiver holds off for a long stretch while a
		// burst of tiny frames keeps coming, so that the result register
		// fills, a last byte parks in the input register and frame.ready drops.
		@(posedge clk);
		hold_left <= HOLD_CYCLES;
		for (int i = 0; i < 24; i++)
			push_raw($urandom_range(1, 3));
		build_frame(FK_GOOD, FILL_RANDOM, 2, 2);
		build_frame(FK_BAD_CSUM, FILL_RANDOM, 0, 0);
		wait_drained();

		// Random frames, one batch under each idling pattern.
		for (int phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 72;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 72;
				end
				default: begin
					send_idle_pct  = 25;
					recv_stall_pct = 25;
				end
			endcase
			start_bytes = queued_bytes;
			while (queued_bytes - start_bytes < PHASE_BYTES)
				random_frame();
			wait_drained();
		end

		// Let any stray result surface before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
